// ===== sv/rcfft_pkg.sv =====
// Package for the radix-2 complex FFT unit: sizes, point type, FSM states,
// twiddle ROM and saturation helpers. No dependencies.
package rcfft_pkg;

   localparam int NUM_POINTS        = 64;
   localparam int LOG2N             = 6;
   localparam int ADDR_WIDTH        = 6;
   localparam int DATA_WIDTH        = 48;
   localparam int TWIDDLE_FRAC_BITS = 30;
   localparam int TW_WIDTH          = 32;
   localparam int HALF_WIDTH        = DATA_WIDTH / 2;
   localparam int PROD_WIDTH        = DATA_WIDTH + TW_WIDTH;
   localparam int ACC_WIDTH         = PROD_WIDTH + 2;
   localparam int ROM_SHIFT         = 30 - TWIDDLE_FRAC_BITS;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [TW_WIDTH-1:0]   tw_type;
   typedef logic [ADDR_WIDTH-1:0]        addr_type;

   typedef struct packed {
      data_type re;
      data_type im;
   } point_type;

   typedef struct packed {
      tw_type wr;
      tw_type wi;
   } twiddle_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PAD,
      ST_RD,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_RND,
      ST_WA,
      ST_WB,
      ST_OUT_RD,
      ST_OUT_HOLD
   } state_type;

   // sin(k*pi/32), k = 0..16, Q1.30
   function automatic logic [30:0] sin_q30(input logic [4:0] k);
      logic [30:0] q;
      case (k)
         5'd0:    q = 31'd0;
         5'd1:    q = 31'd105245103;
         5'd2:    q = 31'd209476638;
         5'd3:    q = 31'd311690799;
         5'd4:    q = 31'd410903207;
         5'd5:    q = 31'd506158392;
         5'd6:    q = 31'd596538995;
         5'd7:    q = 31'd681174602;
         5'd8:    q = 31'd759250125;
         5'd9:    q = 31'd830013654;
         5'd10:   q = 31'd892783698;
         5'd11:   q = 31'd946955747;
         5'd12:   q = 31'd992008094;
         5'd13:   q = 31'd1027506862;
         5'd14:   q = 31'd1053110176;
         5'd15:   q = 31'd1068571464;
         default: q = 31'd1073741824;
      endcase
      return q;
   endfunction

   function automatic tw_type rom_scaled(input logic [4:0] k);
      logic [31:0] q;
      q = {1'b0, sin_q30(k)};
      if (ROM_SHIFT > 0)
         q = (q + (32'd1 << (ROM_SHIFT - 1))) >> ROM_SHIFT;
      return signed'(q);
   endfunction

   function automatic twiddle_type twiddle(input logic [4:0] k, input logic inv);
      twiddle_type t;
      tw_type      sv;
      if (k <= 5'd16) begin
         t.wr = rom_scaled(5'd16 - k);
         sv   = rom_scaled(k);
      end else begin
         t.wr = -rom_scaled(k - 5'd16);
         sv   = rom_scaled(5'(6'd32 - 6'(k)));
      end
      t.wi = inv ? -sv : sv;
      return t;
   endfunction

   function automatic addr_type bit_rev(input addr_type v);
      addr_type r;
      for (int b = 0; b < ADDR_WIDTH; b++)
         r[b] = v[ADDR_WIDTH-1-b];
      return r;
   endfunction

   // saturate a one-bit-grown sum to DATA_WIDTH
   function automatic data_type sat_grow(input logic signed [DATA_WIDTH:0] v);
      data_type r;
      if (v[DATA_WIDTH] != v[DATA_WIDTH-1])
         r = v[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      else
         r = v[DATA_WIDTH-1:0];
      return r;
   endfunction

   // add half LSB, shift by the twiddle fraction, saturate
   function automatic data_type round_sat(input logic signed [ACC_WIDTH-1:0] v);
      logic signed [ACC_WIDTH-1:0] s;
      logic                        all0;
      logic                        all1;
      data_type                    r;
      s = (v + (ACC_WIDTH'(1) <<< (TWIDDLE_FRAC_BITS - 1))) >>> TWIDDLE_FRAC_BITS;
      all0 = ~|s[ACC_WIDTH-1:DATA_WIDTH-1];
      all1 = &s[ACC_WIDTH-1:DATA_WIDTH-1];
      if (all0 || all1)
         r = s[DATA_WIDTH-1:0];
      else if (s[ACC_WIDTH-1])
         r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else
         r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      return r;
   endfunction

endpackage

// ===== sv/rcfft_if.sv =====
// Valid/ready channel interfaces for the radix-2 complex FFT unit.
// Depends on rcfft_pkg.
interface rcfft_req_if;
   import rcfft_pkg::*;
   logic     valid;
   logic     ready;
   logic     mode;
   data_type sample_re;
   data_type sample_im;
   logic     sample_last;
   modport source (output valid, mode, sample_re, sample_im, sample_last, input ready);
   modport sink (input valid, mode, sample_re, sample_im, sample_last, output ready);
endinterface

interface rcfft_rsp_if;
   import rcfft_pkg::*;
   logic     valid;
   logic     ready;
   data_type out_re;
   data_type out_im;
   logic     out_last;
   modport source (output valid, out_re, out_im, out_last, input ready);
   modport sink (input valid, out_re, out_im, out_last, output ready);
endinterface

// ===== sv/radix2_complex_fft_unit.sv =====
// Radix-2 decimation-in-time FFT unit, memory based, one butterfly engine.
// Depends on rcfft_pkg and rcfft_if.
//
// Collects up to 64 points per frame (one per cycle on req), zero pads after a
// point marked last, runs 6 stages of 32 butterflies in place on a 64-entry
// two-read/one-write point memory, then returns 64 results in frequency order
// on rsp, the last one flagged. Per frame: L load writes, 64-L pad writes,
// 192 butterflies (read, two partial-product steps with a 24x32 split,
// combine, round, write a, write b: one memory write port), then for each
// result a read state and a hold state that lasts until rsp accepts it.
// Mode is taken from the first point of a frame. Inverse mode negates the
// twiddle sine and returns floor(re/64 + 1/2) with a zero imaginary part.
// No new point is taken until the last result of a frame has transferred.
module radix2_complex_fft_unit (
   input logic          clock,
   input logic          reset,
   rcfft_req_if.sink    req,
   rcfft_rsp_if.source  rsp
);
   import rcfft_pkg::*;

   // point memory (no reset, every entry written before it is read)
   point_type mem [NUM_POINTS];

   state_type  state_ff, state_in;
   logic [ADDR_WIDTH:0] load_count_ff, load_count_in;
   addr_type   pad_idx_ff, pad_idx_in;
   logic [2:0] stage_ff, stage_in;
   logic [ADDR_WIDTH-2:0] bfly_ff, bfly_in;
   addr_type   out_idx_ff, out_idx_in;
   logic       frame_mode_ff, frame_mode_in;

   // memory ports
   logic       mem_we;
   addr_type   mem_wa;
   point_type  mem_wd;
   logic       rd_en;
   addr_type   rd_addr_a;
   addr_type   rd_addr_b;
   point_type  rd_a_ff, rd_b_ff;

   // butterfly datapath
   twiddle_type tw_ff;
   logic signed [HALF_WIDTH+TW_WIDTH:0]   plo_rr_ff, plo_ii_ff, plo_ir_ff, plo_ri_ff;
   logic signed [HALF_WIDTH+TW_WIDTH-1:0] phi_rr_ff, phi_ii_ff, phi_ir_ff, phi_ri_ff;
   logic signed [PROD_WIDTH-1:0] f_rr_ff, f_ii_ff, f_ir_ff, f_ri_ff;
   data_type   pr_ff, pi_ff;

   // butterfly addressing: pair (a, a + h) with h = 2^stage
   addr_type   span;
   addr_type   bfly_ext;
   addr_type   addr_a;
   addr_type   addr_b;
   logic [4:0] tw_k;
   logic       accept;
   logic       first_pt;
   logic       cur_mode;
   logic [ADDR_WIDTH:0] count_next;
   logic signed [DATA_WIDTH:0] inv_sum;

   always_comb begin
      span     = addr_type'(1) << stage_ff;
      bfly_ext = {1'b0, bfly_ff};
      addr_a   = ((bfly_ext >> stage_ff) << (stage_ff + 3'd1)) | (bfly_ext & (span - 1'b1));
      addr_b   = addr_a | span;
      tw_k     = 5'((bfly_ext & (span - 1'b1)) << (3'd5 - stage_ff));
   end

   assign accept     = req.valid && req.ready;
   assign first_pt   = (load_count_ff == '0);
   assign cur_mode   = first_pt ? req.mode : frame_mode_ff;
   assign count_next = load_count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         pad_idx_ff    <= '0;
         stage_ff      <= '0;
         bfly_ff       <= '0;
         out_idx_ff    <= '0;
         frame_mode_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         pad_idx_ff    <= pad_idx_in;
         stage_ff      <= stage_in;
         bfly_ff       <= bfly_in;
         out_idx_ff    <= out_idx_in;
         frame_mode_ff <= frame_mode_in;
      end
   end

   // sequencer: next state, counters, memory port controls
   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      pad_idx_in    = pad_idx_ff;
      stage_in      = stage_ff;
      bfly_in       = bfly_ff;
      out_idx_in    = out_idx_ff;
      frame_mode_in = frame_mode_ff;
      req.ready     = 1'b0;
      rsp.valid     = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = addr_a;
      mem_wd        = '0;
      rd_en         = 1'b0;
      rd_addr_a     = addr_a;
      rd_addr_b     = addr_b;
      case (state_ff)
         ST_LOAD: begin
            req.ready = 1'b1;
            // points land in bit-reversed slots, so no reorder pass is needed
            mem_wa    = bit_rev(load_count_ff[ADDR_WIDTH-1:0]);
            mem_wd.re = req.sample_re;
            mem_wd.im = cur_mode ? req.sample_im : '0;
            if (accept) begin
               mem_we        = 1'b1;
               frame_mode_in = cur_mode;
               load_count_in = count_next;
               if (req.sample_last || count_next == (ADDR_WIDTH+1)'(NUM_POINTS)) begin
                  load_count_in = '0;
                  stage_in      = '0;
                  bfly_in       = '0;
                  if (count_next == (ADDR_WIDTH+1)'(NUM_POINTS)) begin
                     state_in = ST_RD;
                  end else begin
                     pad_idx_in = count_next[ADDR_WIDTH-1:0];
                     state_in   = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            mem_we     = 1'b1;
            mem_wa     = bit_rev(pad_idx_ff);
            pad_idx_in = pad_idx_ff + 1'b1;
            if (pad_idx_ff == addr_type'(NUM_POINTS - 1))
               state_in = ST_RD;
         end
         ST_RD: begin
            rd_en    = 1'b1;
            state_in = ST_M0;
         end
         ST_M0:  state_in = ST_M1;
         ST_M1:  state_in = ST_M2;
         ST_M2:  state_in = ST_RND;
         ST_RND: state_in = ST_WA;
         ST_WA: begin
            mem_we    = 1'b1;
            mem_wa    = addr_a;
            mem_wd.re = sat_grow((DATA_WIDTH+1)'(rd_a_ff.re) + (DATA_WIDTH+1)'(pr_ff));
            mem_wd.im = sat_grow((DATA_WIDTH+1)'(rd_a_ff.im) + (DATA_WIDTH+1)'(pi_ff));
            state_in  = ST_WB;
         end
         ST_WB: begin
            mem_we    = 1'b1;
            mem_wa    = addr_b;
            mem_wd.re = sat_grow((DATA_WIDTH+1)'(rd_a_ff.re) - (DATA_WIDTH+1)'(pr_ff));
            mem_wd.im = sat_grow((DATA_WIDTH+1)'(rd_a_ff.im) - (DATA_WIDTH+1)'(pi_ff));
            bfly_in   = bfly_ff + 1'b1;
            state_in  = ST_RD;
            if (bfly_ff == '1) begin
               stage_in = stage_ff + 1'b1;
               if (stage_ff == 3'(LOG2N - 1)) begin
                  out_idx_in = '0;
                  state_in   = ST_OUT_RD;
               end
            end
         end
         ST_OUT_RD: begin
            rd_en     = 1'b1;
            rd_addr_a = out_idx_ff;
            state_in  = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               out_idx_in = out_idx_ff + 1'b1;
               state_in   = (out_idx_ff == addr_type'(NUM_POINTS - 1)) ? ST_LOAD : ST_OUT_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_wa] <= mem_wd;
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   // butterfly arithmetic, one step per sequencer state
   always_ff @(posedge clock) begin
      if (state_ff == ST_RD)
         tw_ff <= twiddle(tw_k, frame_mode_ff);
      if (state_ff == ST_M0) begin
         // low halves, taken as unsigned
         plo_rr_ff <= signed'({1'b0, rd_b_ff.re[HALF_WIDTH-1:0]}) * tw_ff.wr;
         plo_ii_ff <= signed'({1'b0, rd_b_ff.im[HALF_WIDTH-1:0]}) * tw_ff.wi;
         plo_ir_ff <= signed'({1'b0, rd_b_ff.im[HALF_WIDTH-1:0]}) * tw_ff.wr;
         plo_ri_ff <= signed'({1'b0, rd_b_ff.re[HALF_WIDTH-1:0]}) * tw_ff.wi;
      end
      if (state_ff == ST_M1) begin
         phi_rr_ff <= signed'(rd_b_ff.re[DATA_WIDTH-1:HALF_WIDTH]) * tw_ff.wr;
         phi_ii_ff <= signed'(rd_b_ff.im[DATA_WIDTH-1:HALF_WIDTH]) * tw_ff.wi;
         phi_ir_ff <= signed'(rd_b_ff.im[DATA_WIDTH-1:HALF_WIDTH]) * tw_ff.wr;
         phi_ri_ff <= signed'(rd_b_ff.re[DATA_WIDTH-1:HALF_WIDTH]) * tw_ff.wi;
      end
      if (state_ff == ST_M2) begin
         f_rr_ff <= PROD_WIDTH'(plo_rr_ff) + (PROD_WIDTH'(phi_rr_ff) <<< HALF_WIDTH);
         f_ii_ff <= PROD_WIDTH'(plo_ii_ff) + (PROD_WIDTH'(phi_ii_ff) <<< HALF_WIDTH);
         f_ir_ff <= PROD_WIDTH'(plo_ir_ff) + (PROD_WIDTH'(phi_ir_ff) <<< HALF_WIDTH);
         f_ri_ff <= PROD_WIDTH'(plo_ri_ff) + (PROD_WIDTH'(phi_ri_ff) <<< HALF_WIDTH);
      end
      if (state_ff == ST_RND) begin
         pr_ff <= round_sat(ACC_WIDTH'(f_rr_ff) - ACC_WIDTH'(f_ii_ff));
         pi_ff <= round_sat(ACC_WIDTH'(f_ir_ff) + ACC_WIDTH'(f_ri_ff));
      end
   end

   // result: inverse mode gives floor((re + N/2) / N)
   assign inv_sum      = (DATA_WIDTH+1)'(rd_a_ff.re) + (DATA_WIDTH+1)'(NUM_POINTS / 2);
   assign rsp.out_re   = frame_mode_ff ? DATA_WIDTH'(inv_sum >>> LOG2N) : rd_a_ff.re;
   assign rsp.out_im   = frame_mode_ff ? '0 : rd_a_ff.im;
   assign rsp.out_last = (out_idx_ff == addr_type'(NUM_POINTS - 1));

`ifndef SYNTHESIS
   a_no_load_during_output: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("point taken while a result is pending");
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.out_last) |=> (state_ff == ST_LOAD && load_count_ff == '0))
      else $error("frame did not restart after last result");
   a_pad_only_after_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && state_in == ST_PAD) |-> req.sample_last)
      else $error("padding without a last point");
   a_bfly_write_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WA) |=> (state_ff == ST_WB && $stable(bfly_ff)))
      else $error("butterfly pair split");
`endif

endmodule
